// File: rtl/tbce_pkg.sv
// ----------------------------------------------------------------------------
// tbce_pkg
// Types, codes and constants shared by the timed bus command encoder.
// ----------------------------------------------------------------------------
package tbce_pkg;

  // Default depth of the queue between front and back.
  localparam int QueueDepth = 4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_RATIO    = 2'd1;
  localparam logic [1:0] CFG_MAX_DEBT = 2'd2;

  // Input function codes.
  localparam logic [2:0] FUNC_WRITE   = 3'd0;
  localparam logic [2:0] FUNC_WAIT    = 3'd1;
  localparam logic [2:0] FUNC_SPECIAL = 3'd2;
  localparam logic [2:0] FUNC_FLUSH   = 3'd3;
  localparam logic [2:0] FUNC_START   = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_WORD = 2'd0;
  localparam logic [1:0] KIND_WAIT = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [20:0] CapLimit      = 21'h100000;
  localparam logic [7:0]  RatioReset    = 8'd1;
  localparam logic [31:0] MaxDebtReset  = 32'hFFFF_FFFF;

  localparam logic [30:0] DelayMax      = 31'h7FFF_FFFF;
  localparam logic [4:0]  StepOpcode    = 5'h01;
  localparam logic [31:0] SpecialDebt   = 32'd3;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_WAIT,
    OP_SPECIAL,
    OP_START
  } op_t;

  // One classified command in the queue.
  typedef struct packed {
    op_t         op;
    logic [31:0] arg_high;
    logic [31:0] arg_low;
  } cmd_t;

  typedef struct packed {
    logic [20:0] buffer_capacity;
    logic [7:0]  bus_clock_ratio;
    logic [31:0] max_debt_cycles;
  } cfg_t;

  // Result as the back end produces it; the time sum is formed later.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] command_low;
    logic [31:0] command_high;
    logic [19:0] entry_index;
    logic        debt_exceeded;
    logic        last;
    logic [47:0] abs_time;
    logic [31:0] pend_delay;
  } rslt_t;

endpackage

// File: rtl/tbce_if.sv
// ----------------------------------------------------------------------------
// tbce_if
// Valid/ready channels for commands into and results out of the encoder.
// ----------------------------------------------------------------------------
interface tbce_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [30:0] wait_cycles;
  logic [15:0] bus_address;
  logic [15:0] bus_data;
  logic [31:0] special_high;
  logic [31:0] special_low;

  modport source (
    output valid, func, wait_cycles, bus_address, bus_data, special_high, special_low,
    input  ready
  );
  modport sink (
    input  valid, func, wait_cycles, bus_address, bus_data, special_high, special_low,
    output ready
  );
endinterface

interface tbce_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] command_low;
  logic [31:0] command_high;
  logic [19:0] entry_index;
  logic        debt_exceeded;
  logic [47:0] current_time;
  logic        last;

  modport source (
    output valid, kind, command_low, command_high, entry_index, debt_exceeded,
           current_time, last,
    input  ready
  );
  modport sink (
    input  valid, kind, command_low, command_high, entry_index, debt_exceeded,
           current_time, last,
    output ready
  );
endinterface

// File: rtl/timed_bus_command_encoder_top.sv
// A command passes the queue, the back-end result and the output registers.
// Throughput: one command per cycle while the result sink is ready, limited by
// the single-result back end; a special command flushing a held bus word is split.
// Reset (synchronous, active high) empties the queue and pipeline, restores the
// configuration defaults and starts a fresh sequence.
// ----------------------------------------------------------------------------
// timed_bus_command_encoder_top
// Builds 64-bit sequencer command words from bus writes, waits and specials.
// ----------------------------------------------------------------------------
module timed_bus_command_encoder_top import tbce_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  tbce_cmd_if.sink    cmd_in,
  tbce_res_if.source  res_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t  cfg;
  logic  push;
  cmd_t  push_cmd;
  logic  queue_full;
  logic  cmd_pop;
  logic  cmd_valid;
  cmd_t  cmd;
  logic  rslt_valid;
  rslt_t rslt;
  logic  out_valid;
  logic  out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buffer_capacity <= CapLimit;
      cfg.bus_clock_ratio <= RatioReset;
      cfg.max_debt_cycles <= MaxDebtReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY: cfg.buffer_capacity <= cfg_data[20:0];
        CFG_RATIO:    cfg.bus_clock_ratio <= cfg_data[7:0];
        CFG_MAX_DEBT: cfg.max_debt_cycles <= cfg_data;
        default:      cfg                 <= cfg;
      endcase
    end
  end

  tbce_front u_front (
    .cmd_in     (cmd_in),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  tbce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (cmd_pop),
    .avail    (cmd_valid),
    .head     (cmd)
  );

  tbce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .rslt_valid (rslt_valid),
    .rslt       (rslt),
    .rslt_ready (out_adv)
  );

  // Output register; the sequence time is summed on the way in.
  assign out_adv       = !out_valid || res_out.ready;
  assign res_out.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= rslt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && rslt_valid) begin
      res_out.kind          <= rslt.kind;
      res_out.command_low   <= rslt.command_low;
      res_out.command_high  <= rslt.command_high;
      res_out.entry_index   <= rslt.entry_index;
      res_out.debt_exceeded <= rslt.debt_exceeded;
      res_out.last          <= rslt.last;
      res_out.current_time  <= rslt.abs_time + {16'h0, rslt.pend_delay};
    end
  end

endmodule

// File: rtl/tbce_front.sv
// ----------------------------------------------------------------------------
// tbce_front
// Accepts input words, decodes the function and pushes a compact command.
// ----------------------------------------------------------------------------
module tbce_front import tbce_pkg::*; (
  tbce_cmd_if.sink cmd_in,
  input  logic     queue_full,
  output logic     push,
  output cmd_t     push_cmd
);

  logic take;

  assign cmd_in.ready = !queue_full;
  assign take         = cmd_in.valid && !queue_full;

  always_comb begin
    push              = 1'b0;
    push_cmd.op       = OP_WRITE;
    push_cmd.arg_high = '0;
    push_cmd.arg_low  = '0;
    unique case (cmd_in.func)
      FUNC_WRITE: begin
        push             = take;
        push_cmd.arg_low = {cmd_in.bus_address, cmd_in.bus_data};
      end
      FUNC_WAIT: begin
        push             = take;
        push_cmd.op      = OP_WAIT;
        push_cmd.arg_low = {1'b0, cmd_in.wait_cycles};
      end
      FUNC_SPECIAL: begin
        push              = take;
        push_cmd.op       = OP_SPECIAL;
        push_cmd.arg_high = cmd_in.special_high;
        push_cmd.arg_low  = cmd_in.special_low;
      end
      // A flush is a bus write of zero content.
      FUNC_FLUSH: begin
        push = take;
      end
      FUNC_START: begin
        push        = take;
        push_cmd.op = OP_START;
      end
      // Unknown functions are accepted and discarded.
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/tbce_queue.sv
// ----------------------------------------------------------------------------
// tbce_queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tbce_queue import tbce_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  cmd_t            entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == FullCnt);
  assign avail   = (count != '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: rtl/tbce_back.sv
// ----------------------------------------------------------------------------
// tbce_back
// Executes commands on the timing state, one result per cycle unless stalled.
// ----------------------------------------------------------------------------
module tbce_back import tbce_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  cmd_valid,
  input  cmd_t  cmd,
  output logic  cmd_pop,
  output logic  rslt_valid,
  output rslt_t rslt,
  input  logic  rslt_ready
);

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Clamp a 34-bit sum into the 33-bit signed debt range.
  function automatic logic [32:0] debt_clamp(logic [33:0] s);
    logic [32:0] r;
    if (s[33] != s[32]) begin
      r = s[33] ? {1'b1, 32'h0} : {1'b0, 32'hFFFF_FFFF};
    end else begin
      r = s[32:0];
    end
    return r;
  endfunction

  logic [20:0] entry_count, entry_count_next;
  logic [31:0] held_bus_word, held_bus_word_next;
  logic        last_was_special, last_was_special_next;
  logic [31:0] pending_delay, pending_delay_next;
  logic [31:0] time_debt, time_debt_next;
  logic [32:0] current_debt, current_debt_next;
  logic [47:0] absolute_time, absolute_time_next;
  logic        phase, phase_next;

  logic        advance;
  logic        go;
  logic        emit;
  rslt_t       rslt_d;
  logic [20:0] cap_eff;
  logic        full;

  // Shared bus-write datapath.
  logic [31:0] wr_content;
  logic        wr_zero;
  logic [31:0] wr_ratio;
  logic [31:0] wr_spacing;
  logic [31:0] wr_debt;
  logic [32:0] wr_cdebt;
  logic [47:0] wr_abs;
  logic [30:0] wr_delay;

  // Wait datapath.
  logic [31:0] wt_pend;
  logic [31:0] wt_pend_out;
  logic [31:0] wt_debt;
  logic [32:0] wt_cdebt;
  logic        wt_exc;

  assign cap_eff = (cfg.buffer_capacity > CapLimit) ? CapLimit : cfg.buffer_capacity;
  assign full    = (entry_count >= cap_eff);
  assign advance = !rslt_valid || rslt_ready;
  assign go      = cmd_valid && advance;

  assign wr_content = (cmd.op == OP_SPECIAL) ? held_bus_word : cmd.arg_low;
  assign wr_ratio   = {24'h0, cfg.bus_clock_ratio};
  assign wr_zero    = (pending_delay == '0);
  assign wr_spacing = wr_zero ? wr_ratio : pending_delay;
  assign wr_debt    = wr_zero ? sat_add32(time_debt, wr_ratio) : time_debt;
  assign wr_cdebt   = wr_zero ? debt_clamp({current_debt[32], current_debt} + {2'b0, wr_ratio})
                              : current_debt;
  assign wr_abs     = absolute_time + {16'h0, pending_delay}
                    + {{15{wr_cdebt[32]}}, wr_cdebt};
  assign wr_delay   = wr_spacing[31] ? DelayMax : wr_spacing[30:0];

  // A wait pays off outstanding debt before it adds to the pending delay.
  always_comb begin
    wt_pend     = sat_add32(pending_delay, cmd.arg_low);
    wt_pend_out = wt_pend;
    wt_debt     = time_debt;
    wt_cdebt    = current_debt;
    wt_exc      = 1'b0;
    if (time_debt != '0) begin
      if (wt_pend > time_debt) begin
        wt_pend_out = wt_pend - time_debt;
        wt_debt     = '0;
        wt_cdebt    = '0;
      end else begin
        wt_pend_out = '0;
        wt_debt     = time_debt - wt_pend;
        wt_cdebt    = debt_clamp({current_debt[32], current_debt} - {2'b0, wt_pend});
      end
      wt_exc = (wt_debt > cfg.max_debt_cycles);
    end
  end

  always_comb begin
    entry_count_next      = entry_count;
    held_bus_word_next    = held_bus_word;
    last_was_special_next = last_was_special;
    pending_delay_next    = pending_delay;
    time_debt_next        = time_debt;
    current_debt_next     = current_debt;
    absolute_time_next    = absolute_time;
    phase_next            = phase;
    cmd_pop               = 1'b0;
    emit                  = 1'b0;

    rslt_d.kind          = KIND_DROP;
    rslt_d.command_low   = '0;
    rslt_d.command_high  = '0;
    rslt_d.entry_index   = '0;
    rslt_d.debt_exceeded = 1'b0;
    rslt_d.last          = 1'b1;
    rslt_d.abs_time      = absolute_time;
    rslt_d.pend_delay    = pending_delay;

    // The first half of a special command flushes the held bus word.
    if ((cmd.op == OP_WRITE) || ((cmd.op == OP_SPECIAL) && !phase && !last_was_special)) begin
      if (cmd.op == OP_SPECIAL) begin
        rslt_d.last = 1'b0;
        phase_next  = 1'b1;
      end else begin
        cmd_pop = go;
      end
      if (full) begin
        emit = 1'b1;
      end else begin
        time_debt_next        = wr_debt;
        current_debt_next     = '0;
        absolute_time_next    = wr_abs;
        pending_delay_next    = '0;
        held_bus_word_next    = wr_content;
        last_was_special_next = 1'b0;
        rslt_d.abs_time       = wr_abs;
        rslt_d.pend_delay     = '0;
        if (!last_was_special) begin
          emit                = 1'b1;
          entry_count_next    = entry_count + 1'b1;
          rslt_d.kind         = KIND_WORD;
          rslt_d.command_low  = {wr_delay[26:0], StepOpcode};
          rslt_d.command_high = {held_bus_word[27:0], wr_delay[30:27]};
          rslt_d.entry_index  = entry_count[19:0];
        end
      end
    end else begin
      cmd_pop = go;
      unique case (cmd.op)
        OP_WAIT: begin
          emit                 = 1'b1;
          pending_delay_next   = wt_pend_out;
          time_debt_next       = wt_debt;
          current_debt_next    = wt_cdebt;
          rslt_d.kind          = KIND_WAIT;
          rslt_d.debt_exceeded = wt_exc;
          rslt_d.pend_delay    = wt_pend_out;
        end
        OP_SPECIAL: begin
          emit       = 1'b1;
          phase_next = 1'b0;
          if (!full) begin
            entry_count_next      = entry_count + 1'b1;
            last_was_special_next = 1'b1;
            time_debt_next        = sat_add32(time_debt, SpecialDebt);
            current_debt_next     = debt_clamp({current_debt[32], current_debt}
                                               + {2'b0, SpecialDebt});
            rslt_d.kind           = KIND_WORD;
            rslt_d.command_low    = cmd.arg_low;
            rslt_d.command_high   = cmd.arg_high;
            rslt_d.entry_index    = entry_count[19:0];
          end
        end
        OP_START: begin
          entry_count_next      = '0;
          held_bus_word_next    = '0;
          last_was_special_next = 1'b1;
          pending_delay_next    = '0;
          time_debt_next        = '0;
          current_debt_next     = '0;
          absolute_time_next    = '0;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count      <= '0;
      held_bus_word    <= '0;
      last_was_special <= 1'b1;
      pending_delay    <= '0;
      time_debt        <= '0;
      current_debt     <= '0;
      absolute_time    <= '0;
      phase            <= 1'b0;
      rslt_valid       <= 1'b0;
    end else begin
      if (go) begin
        entry_count      <= entry_count_next;
        held_bus_word    <= held_bus_word_next;
        last_was_special <= last_was_special_next;
        pending_delay    <= pending_delay_next;
        time_debt        <= time_debt_next;
        current_debt     <= current_debt_next;
        absolute_time    <= absolute_time_next;
        phase            <= phase_next;
      end
      if (advance) begin
        rslt_valid <= go && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      rslt <= rslt_d;
    end
  end

endmodule

// File: tb/sv/tb_timed_bus_command_encoder_top.sv
// ----------------------------------------------------------------------------
// tb_timed_bus_command_encoder_top
// Self-checking bench for the timed bus command encoder. A cycle-free model of
// the encoder predicts every result word from the accepted commands. Directed
// tests cover field extremes, debt handling, specials and the buffer capacity.
// Random traffic then runs under several register settings, in most phases with
// bursty input and a stalling result sink.
// ----------------------------------------------------------------------------
module tb_timed_bus_command_encoder_top;
  import tbce_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 9;
  localparam int IDLE_TAIL      = 24;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS          = 1000;
  localparam int PHASES         = 8;
  localparam int MAX_REPORTS    = 10;

  localparam longint OPEN_DEBT_MAX = 64'sd4294967295;
  localparam longint OPEN_DEBT_MIN = -64'sd4294967296;

  typedef enum int {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PERIODIC,
    SINK_LONG
  } sink_mode_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [30:0] wait_cycles;
    logic [15:0] addr;
    logic [15:0] data;
    logic [31:0] sp_hi;
    logic [31:0] sp_lo;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [19:0] idx;
    logic        exc;
    logic [47:0] ctime;
    logic        last;
  } res_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  tbce_cmd_if cmd_if();
  tbce_res_if res_if();

  timed_bus_command_encoder_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_in    (cmd_if),
    .res_out   (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Model registers and sequence state.
  logic [20:0] cap_reg;
  logic [7:0]  ratio_reg;
  logic [31:0] debt_limit_reg;
  logic [20:0] entry_cnt;
  logic [31:0] held_word;
  logic        after_special;
  logic [31:0] pending_cyc;
  logic [31:0] debt_cyc;
  longint      open_debt;
  logic [47:0] seq_time;

  res_word_t   encoded_words[$];

  int          fail_count;
  int          quiet_cycles;
  int          burst_left;
  bit          sender_bursts;
  sink_mode_t  sink_mode;
  int unsigned sink_tick;

  // ---------------------------------------------------------------- model

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void add_open_debt(longint v);
    open_debt = open_debt + v;
    if (open_debt > OPEN_DEBT_MAX) open_debt = OPEN_DEBT_MAX;
    if (open_debt < OPEN_DEBT_MIN) open_debt = OPEN_DEBT_MIN;
  endfunction

  function automatic bit buffer_full();
    logic [20:0] lim;
    lim = (cap_reg > CapLimit) ? CapLimit : cap_reg;
    return entry_cnt >= lim;
  endfunction

  function automatic void push_word(logic [1:0] kind, logic [31:0] lo, logic [31:0] hi,
                                    logic [19:0] idx, logic exc);
    res_word_t w;
    w.kind  = kind;
    w.lo    = lo;
    w.hi    = hi;
    w.idx   = idx;
    w.exc   = exc;
    w.ctime = seq_time + {16'b0, pending_cyc};
    w.last  = 1'b0;
    encoded_words.push_back(w);
  endfunction

  function automatic void restart_sequence();
    entry_cnt     = '0;
    held_word     = '0;
    after_special = 1'b1;
    pending_cyc   = '0;
    debt_cyc      = '0;
    open_debt     = 0;
    seq_time      = '0;
  endfunction

  function automatic void encode_bus_write(logic [31:0] content);
    logic [31:0] spacing;
    logic [31:0] d;
    longint      ratio_l;
    if (buffer_full()) begin
      push_word(KIND_DROP, '0, '0, '0, 1'b0);
      return;
    end
    spacing = pending_cyc;
    if (spacing == 0) begin
      // A back-to-back write still needs the bus spacing; it is owed as debt.
      spacing  = {24'b0, ratio_reg};
      ratio_l  = longint'(ratio_reg);
      debt_cyc = sat_add32(debt_cyc, {24'b0, ratio_reg});
      add_open_debt(ratio_l);
    end
    seq_time    = seq_time + {16'b0, pending_cyc} + 48'(open_debt);
    pending_cyc = '0;
    open_debt   = 0;
    if (!after_special) begin
      d = (spacing > {1'b0, DelayMax}) ? {1'b0, DelayMax} : spacing;
      push_word(KIND_WORD, {d[26:0], StepOpcode}, {held_word[27:0], d[30:27]},
                entry_cnt[19:0], 1'b0);
      entry_cnt = entry_cnt + 21'd1;
    end
    held_word     = content;
    after_special = 1'b0;
  endfunction

  function automatic void encode_wait(logic [30:0] cycles);
    logic   exc;
    longint paid;
    exc         = 1'b0;
    pending_cyc = sat_add32(pending_cyc, {1'b0, cycles});
    if (debt_cyc != 0) begin
      if (pending_cyc > debt_cyc) begin
        pending_cyc = pending_cyc - debt_cyc;
        open_debt   = 0;
        debt_cyc    = '0;
      end else begin
        paid        = longint'(pending_cyc);
        debt_cyc    = debt_cyc - pending_cyc;
        add_open_debt(-paid);
        pending_cyc = '0;
      end
      exc = debt_cyc > debt_limit_reg;
    end
    push_word(KIND_WAIT, '0, '0, '0, exc);
  endfunction

  function automatic void encode_special(logic [31:0] hi, logic [31:0] lo);
    longint extra;
    extra = longint'(SpecialDebt);
    if (!after_special) encode_bus_write(held_word);
    if (buffer_full()) begin
      push_word(KIND_DROP, '0, '0, '0, 1'b0);
      return;
    end
    push_word(KIND_WORD, lo, hi, entry_cnt[19:0], 1'b0);
    entry_cnt     = entry_cnt + 21'd1;
    after_special = 1'b1;
    debt_cyc      = sat_add32(debt_cyc, SpecialDebt);
    add_open_debt(extra);
  endfunction

  function automatic void encode_command(cmd_word_t c);
    int n0;
    n0 = encoded_words.size();
    case (c.func)
      FUNC_WRITE:   encode_bus_write({c.addr, c.data});
      FUNC_WAIT:    encode_wait(c.wait_cycles);
      FUNC_SPECIAL: encode_special(c.sp_hi, c.sp_lo);
      FUNC_FLUSH:   encode_bus_write('0);
      FUNC_START:   restart_sequence();
      default:      ;
    endcase
    if (encoded_words.size() > n0) encoded_words[encoded_words.size() - 1].last = 1'b1;
  endfunction

  // ------------------------------------------------------- command builders

  function automatic cmd_word_t op_cmd(logic [2:0] func);
    cmd_word_t c;
    c.func        = func;
    c.wait_cycles = 31'($urandom);
    c.addr        = 16'($urandom);
    c.data        = 16'($urandom);
    c.sp_hi       = $urandom;
    c.sp_lo       = $urandom;
    return c;
  endfunction

  function automatic cmd_word_t write_cmd(logic [15:0] addr, logic [15:0] data);
    cmd_word_t c;
    c      = op_cmd(FUNC_WRITE);
    c.addr = addr;
    c.data = data;
    return c;
  endfunction

  function automatic cmd_word_t wait_cmd(logic [30:0] cycles);
    cmd_word_t c;
    c             = op_cmd(FUNC_WAIT);
    c.wait_cycles = cycles;
    return c;
  endfunction

  function automatic cmd_word_t special_cmd(logic [31:0] hi, logic [31:0] lo);
    cmd_word_t c;
    c       = op_cmd(FUNC_SPECIAL);
    c.sp_hi = hi;
    c.sp_lo = lo;
    return c;
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_cmd(input cmd_word_t c);
    if (sender_bursts) begin
      if (burst_left == 0) begin
        cmd_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.func         <= c.func;
    cmd_if.wait_cycles  <= c.wait_cycles;
    cmd_if.bus_address  <= c.addr;
    cmd_if.bus_data     <= c.data;
    cmd_if.special_high <= c.sp_hi;
    cmd_if.special_low  <= c.sp_lo;
    // Ready is looked at mid-cycle, where it is settled for the coming edge.
    forever begin
      @(negedge clk);
      if (cmd_if.ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    encode_command(c);
  endtask

  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    while (encoded_words.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CAPACITY: cap_reg        = val[20:0];
      CFG_RATIO:    ratio_reg      = val[7:0];
      CFG_MAX_DEBT: debt_limit_reg = val;
      default:      ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    sink_tick <= sink_tick + 1;
    case (sink_mode)
      SINK_OPEN:     res_if.ready <= 1'b1;
      SINK_RANDOM:   res_if.ready <= ($urandom_range(0, 3) != 0);
      SINK_PERIODIC: res_if.ready <= (sink_tick % 11) >= 3;
      default:       res_if.ready <= (sink_tick % 40) >= 30;
    endcase
  end

  // --------------------------------------------------------------- checking

  function automatic string word_text(res_word_t w);
    return $sformatf("kind=%0d low=%h high=%h index=%h exceeded=%0b time=%h last=%0b",
                     w.kind, w.lo, w.hi, w.idx, w.exc, w.ctime, w.last);
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  always @(negedge clk) begin : check_words
    res_word_t got;
    res_word_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      got.kind  = res_if.kind;
      got.lo    = res_if.command_low;
      got.hi    = res_if.command_high;
      got.idx   = res_if.entry_index;
      got.exc   = res_if.debt_exceeded;
      got.ctime = res_if.current_time;
      got.last  = res_if.last;
      if (encoded_words.size() == 0) begin
        note_failure($sformatf("unexpected word: %s", word_text(got)));
      end else begin
        want = encoded_words.pop_front();
        if (got !== want)
          note_failure($sformatf("word mismatch\n  expected %s\n  actual   %s",
                                 word_text(want), word_text(got)));
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ------------------------------------------------------------------ tests

  task automatic test_bus_writes();
    sink_mode     = SINK_RANDOM;
    sender_bursts = 1'b1;
    // The first write is only held; the second one releases it.
    send_cmd(write_cmd(16'hFFFF, 16'hFFFF));
    send_cmd(write_cmd(16'h0000, 16'h0000));
    send_cmd(wait_cmd(31'd0));
    send_cmd(wait_cmd(31'd5));
    send_cmd(write_cmd(16'hABCD, 16'h1234));
    send_cmd(op_cmd(FUNC_FLUSH));
    send_cmd(op_cmd(3'd5));
    send_cmd(op_cmd(3'd7));
  endtask

  task automatic test_debt_limit();
    wait_idle();
    write_cfg(CFG_MAX_DEBT, 32'd0);
    write_cfg(CFG_RATIO, 32'd255);
    send_cmd(special_cmd(32'h1234_5678, 32'h9ABC_DEF0));
    send_cmd(wait_cmd(31'd1));
    // Three maximal waits saturate the pending delay before the next write.
    send_cmd(wait_cmd(31'h7FFF_FFFF));
    send_cmd(wait_cmd(31'h7FFF_FFFF));
    send_cmd(wait_cmd(31'h7FFF_FFFF));
    send_cmd(write_cmd(16'h5A5A, 16'hA5A5));
  endtask

  task automatic test_special_commands();
    send_cmd(special_cmd(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_cmd(special_cmd(32'h0000_0000, 32'h0000_0000));
  endtask

  task automatic test_capacity();
    wait_idle();
    write_cfg(CFG_CAPACITY, 32'd1);
    send_cmd(op_cmd(FUNC_START));
    send_cmd(write_cmd(16'h0FFF, 16'h8001));
    send_cmd(write_cmd(16'hF000, 16'h7FFE));
    send_cmd(write_cmd(16'h1111, 16'h2222));
    send_cmd(special_cmd(32'hDEAD_BEEF, 32'h0BAD_F00D));
    send_cmd(op_cmd(FUNC_FLUSH));
    wait_idle();
    write_cfg(CFG_CAPACITY, 32'd0);
    send_cmd(op_cmd(FUNC_START));
    send_cmd(write_cmd(16'h3333, 16'h4444));
    wait_idle();
    write_cfg(CFG_CAPACITY, 32'h001F_FFFF);
    write_cfg(CFG_RATIO, 32'd0);
    send_cmd(op_cmd(FUNC_START));
    send_cmd(write_cmd(16'h7777, 16'h8888));
    send_cmd(write_cmd(16'h9999, 16'hAAAA));
  endtask

  task automatic test_random_traffic();
    cmd_word_t   c;
    logic [30:0] w;
    int          sent;
    int          r;
    int          per_phase;
    per_phase = ITEMS / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_cfg(CFG_CAPACITY, {11'b0, CapLimit});
          write_cfg(CFG_RATIO, 32'd1);
          write_cfg(CFG_MAX_DEBT, 32'hFFFF_FFFF);
        end
        1: begin
          write_cfg(CFG_CAPACITY, 32'd16);
          write_cfg(CFG_RATIO, 32'd255);
          write_cfg(CFG_MAX_DEBT, 32'd0);
        end
        2: begin
          write_cfg(CFG_CAPACITY, 32'h001F_FFFF);
          write_cfg(CFG_RATIO, 32'd0);
          write_cfg(CFG_MAX_DEBT, 32'd100);
        end
        3: begin
          write_cfg(CFG_CAPACITY, 32'd1);
          write_cfg(CFG_RATIO, 32'd7);
          write_cfg(CFG_MAX_DEBT, 32'hFFFF_FFFF);
        end
        4: begin
          write_cfg(CFG_CAPACITY, 32'd0);
          write_cfg(CFG_RATIO, 32'd3);
          write_cfg(CFG_MAX_DEBT, 32'd5);
        end
        5: begin
          write_cfg(CFG_CAPACITY, $urandom_range(2, 64));
          write_cfg(CFG_RATIO, $urandom_range(0, 255));
          write_cfg(CFG_MAX_DEBT, $urandom_range(0, 1000));
        end
        6: begin
          write_cfg(CFG_CAPACITY, {11'b0, CapLimit});
          write_cfg(CFG_RATIO, 32'd255);
          write_cfg(CFG_MAX_DEBT, 32'd300);
        end
        default: begin
          write_cfg(CFG_CAPACITY, $urandom_range(0, 2097151));
          write_cfg(CFG_RATIO, $urandom);
          write_cfg(CFG_MAX_DEBT, $urandom);
        end
      endcase
      sink_mode     = sink_mode_t'(ph % 4);
      sender_bursts = (ph % 4) != 0;
      send_cmd(op_cmd(FUNC_START));
      sent = 0;
      while (sent < per_phase) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          c = write_cmd(16'($urandom), 16'($urandom));
        end else if (r < 65) begin
          r = $urandom_range(0, 19);
          if (r < 12)      w = 31'($urandom_range(0, 400));
          else if (r < 15) w = '0;
          else if (r < 18) w = 31'($urandom_range(0, 65535));
          else             w = 31'($urandom);
          c = wait_cmd(w);
        end else if (r < 78) begin
          c = special_cmd($urandom, $urandom);
        end else if (r < 88) begin
          c = op_cmd(FUNC_FLUSH);
        end else if (r < 94) begin
          c = op_cmd(FUNC_START);
        end else if (r < 97) begin
          c = op_cmd(3'($urandom_range(5, 7)));
        end else begin
          c = op_cmd(3'($urandom_range(0, 7)));
        end
        send_cmd(c);
        if (c.func <= FUNC_START) begin
          sent++;
          // Let the whole pipeline drain once in the middle of phases 3 and 6.
          if ((ph == 3 || ph == 6) && sent == per_phase / 2) wait_idle();
        end
      end
    end
  endtask

  initial begin
    cmd_if.valid        = 1'b0;
    cmd_if.func         = FUNC_WRITE;
    cmd_if.wait_cycles  = '0;
    cmd_if.bus_address  = '0;
    cmd_if.bus_data     = '0;
    cmd_if.special_high = '0;
    cmd_if.special_low  = '0;
    res_if.ready        = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_CAPACITY;
    cfg_data            = '0;
    fail_count          = 0;
    quiet_cycles        = 0;
    burst_left          = 0;
    sender_bursts       = 1'b0;
    sink_mode           = SINK_OPEN;
    sink_tick           = 0;
    cap_reg             = CapLimit;
    ratio_reg           = RatioReset;
    debt_limit_reg      = MaxDebtReset;
    restart_sequence();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_bus_writes();
    test_debt_limit();
    test_special_commands();
    test_capacity();
    test_random_traffic();

    wait_idle();
    if (encoded_words.size() != 0)
      note_failure($sformatf("%0d expected words never arrived", encoded_words.size()));
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tbce_pkg.sv
rtl/tbce_if.sv
rtl/tbce_front.sv
rtl/tbce_queue.sv
rtl/tbce_back.sv
rtl/timed_bus_command_encoder_top.sv
tb/sv/tb_timed_bus_command_encoder_top.sv
